FILE: rtl/core/egm_pkg.sv
// Shared constants and types for the dual-gradient energy map.
`timescale 1ns / 1ps
`default_nettype none

package egm_pkg;

  // Field widths
  localparam int CHAN_W    = 8;
  localparam int PIX_W     = 3 * CHAN_W;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int ROW_W     = 11;
  localparam int OUT_COL_W = 11;
  localparam int ENERGY_W  = 19;
  localparam int SQ_W      = 2 * CHAN_W;

  // Frame geometry
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MIN_DIM       = 3;
  localparam logic [CFG_W-1:0] MAX_HEIGHT   = 12'd2048;
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

  // Energy given to every pixel on the frame border
  localparam logic [ENERGY_W-1:0] BORDER_ENERGY = 19'd195075;

  // Words held between front and back
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  // Classification of one pixel word, decided in the front
  typedef struct packed {
    logic has_first;   // energy of the pixel above is due
    logic has_second;  // bottom-row border energy of this pixel is due
    logic border;      // pixel above lies on the border
    logic last;        // this pixel closes the frame
  } egm_flags_t;

endpackage : egm_pkg

`default_nettype wire

FILE: rtl/core/egm_front.sv
// Front end: configuration registers, raster position and pixel classification.
`timescale 1ns / 1ps
`default_nettype none

module egm_front #(
  parameter int MAX_WIDTH = egm_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration write channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [egm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [egm_pkg::CFG_W-1:0]       cfg_data,
  // pixel input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [egm_pkg::CHAN_W-1:0]      red,
  input  wire logic [egm_pkg::CHAN_W-1:0]      green,
  input  wire logic [egm_pkg::CHAN_W-1:0]      blue,
  // push side of the queue
  input  wire logic                            q_full,
  output logic                                 q_push,
  output logic [egm_pkg::PIX_W-1:0]            q_pix,
  output logic [$clog2(MAX_WIDTH)-1:0]         q_col,
  output logic [egm_pkg::ROW_W-1:0]            q_row,
  output egm_pkg::egm_flags_t                  q_flags
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int DIM_W = $clog2(MAX_WIDTH + 1);
  localparam int LW    = (DIM_W > egm_pkg::CFG_W) ? DIM_W : egm_pkg::CFG_W;

  logic [egm_pkg::CFG_W-1:0] frame_width;
  logic [egm_pkg::CFG_W-1:0] frame_height;
  logic [COL_W-1:0]          col;
  logic [egm_pkg::ROW_W-1:0] row;

  logic [LW-1:0]             fw_ext;
  logic [LW-1:0]             eff_w;
  logic [egm_pkg::CFG_W-1:0] eff_h;
  logic                      col_last;
  logic                      row_last;
  logic                      cfg_write;
  logic                      accept;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;
  assign in_stall  = q_full;
  assign accept    = in_valid & ~q_full;

  // Clamp the frame size to the supported range
  always_comb begin
    fw_ext = LW'(frame_width);
    if (fw_ext < LW'(egm_pkg::MIN_DIM)) begin
      eff_w = LW'(egm_pkg::MIN_DIM);
    end else if (fw_ext > LW'(MAX_WIDTH)) begin
      eff_w = LW'(MAX_WIDTH);
    end else begin
      eff_w = fw_ext;
    end
    if (frame_height < egm_pkg::CFG_W'(egm_pkg::MIN_DIM)) begin
      eff_h = egm_pkg::CFG_W'(egm_pkg::MIN_DIM);
    end else if (frame_height > egm_pkg::MAX_HEIGHT) begin
      eff_h = egm_pkg::MAX_HEIGHT;
    end else begin
      eff_h = frame_height;
    end
  end

  assign col_last = (LW'(col) == eff_w - LW'(1));
  assign row_last = (egm_pkg::CFG_W'(row) == eff_h - egm_pkg::CFG_W'(1));

  // Classify the incoming word by its position
  always_comb begin
    q_push             = accept;
    q_pix              = {blue, green, red};
    q_col              = col;
    q_row              = row;
    q_flags.has_first  = (row != '0);
    q_flags.has_second = row_last;
    q_flags.border     = (col == '0) | col_last | (row == egm_pkg::ROW_W'(1));
    q_flags.last       = col_last & row_last;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= egm_pkg::WIDTH_RESET;
      frame_height <= egm_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        egm_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        egm_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the raster position; a write to the width or height register restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cfg_write &&
                 (cfg_index == egm_pkg::REG_FRAME_WIDTH ||
                  cfg_index == egm_pkg::REG_FRAME_HEIGHT)) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_last) begin
        col <= '0;
        row <= row_last ? '0 : egm_pkg::ROW_W'(row + 1'b1);
      end else begin
        col <= COL_W'(col + 1'b1);
      end
    end
  end

endmodule : egm_front

`default_nettype wire

FILE: rtl/core/egm_queue.sv
// Short word queue that decouples the front end from the energy back end.
`timescale 1ns / 1ps
`default_nettype none

module egm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = egm_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      head
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_push   = push & ~full;
  assign do_pop    = pop & not_empty;

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CW'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

endmodule : egm_queue

`default_nettype wire

FILE: rtl/core/egm_back.sv
// Back end: line stores, gradient arithmetic and result sequencing.
`timescale 1ns / 1ps
`default_nettype none

module egm_back #(
  parameter int MAX_WIDTH = egm_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // pop side of the queue
  input  wire logic                            q_valid,
  output logic                                 q_pop,
  input  wire logic [egm_pkg::PIX_W-1:0]       q_pix,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]    q_col,
  input  wire logic [egm_pkg::ROW_W-1:0]       q_row,
  input  wire egm_pkg::egm_flags_t             q_flags,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [egm_pkg::OUT_COL_W-1:0]        out_col,
  output logic [egm_pkg::ROW_W-1:0]            out_row,
  output logic [egm_pkg::ENERGY_W-1:0]         energy,
  output logic                                 frame_done
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CH    = egm_pkg::CHAN_W;

  // Line stores: row above and row two above
  logic [egm_pkg::PIX_W-1:0] prev_row_store  [MAX_WIDTH];
  logic [egm_pkg::PIX_W-1:0] older_row_store [MAX_WIDTH];

  // Stage 1: line store read data
  logic                      s1_valid;
  logic [egm_pkg::PIX_W-1:0] s1_pix;
  logic [COL_W-1:0]          s1_col;
  logic [egm_pkg::ROW_W-1:0] s1_row;
  egm_pkg::egm_flags_t       s1_flags;
  logic [egm_pkg::PIX_W-1:0] rd_above;
  logic [egm_pkg::PIX_W-1:0] rd_right;
  logic [egm_pkg::PIX_W-1:0] rd_older;
  logic [egm_pkg::PIX_W-1:0] left_pix;

  // Stage 2: channel squares
  logic                      s2_valid;
  logic [egm_pkg::ROW_W-1:0] s2_row;
  logic [COL_W-1:0]          s2_col;
  egm_pkg::egm_flags_t       s2_flags;
  logic [egm_pkg::SQ_W-1:0]  s2_sq [6];

  // Stage 3: result word, one or two results
  logic                         s3_valid;
  logic                         s3_phase;
  logic                         s3_has_second;
  logic                         s3_last;
  logic [COL_W-1:0]             s3_col;
  logic [egm_pkg::ROW_W-1:0]    s3_row;
  logic [egm_pkg::ENERGY_W-1:0] s3_energy;

  logic                         out_take;
  logic                         s3_free;
  logic                         s2_ready;
  logic                         s1_ready;
  logic                         s1_adv;
  logic                         s2_adv;
  logic [COL_W-1:0]             col_right;
  logic [egm_pkg::SQ_W-1:0]     sq_next [6];
  logic [egm_pkg::ENERGY_W-1:0] sum_next;

  function automatic logic [egm_pkg::SQ_W-1:0] chan_sq(
    input logic [egm_pkg::CHAN_W-1:0] a,
    input logic [egm_pkg::CHAN_W-1:0] b
  );
    logic [egm_pkg::CHAN_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return egm_pkg::SQ_W'(d) * egm_pkg::SQ_W'(d);
  endfunction

  // Pipeline handshake
  assign out_take  = s3_valid & ~out_stall;
  assign s3_free   = ~s3_valid | (out_take & (s3_phase | ~s3_has_second));
  assign s2_adv    = s2_valid & s3_free;
  assign s2_ready  = ~s2_valid | s3_free;
  assign s1_adv    = s1_valid & s2_ready;
  assign s1_ready  = ~s1_valid | s2_ready;
  assign q_pop     = q_valid & s1_ready;
  assign col_right = COL_W'(q_col + 1'b1);

  // Read the pixel above, its right neighbor and the row two up; store the new pixel
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_above               <= prev_row_store[q_col];
      rd_right               <= prev_row_store[col_right];
      rd_older               <= older_row_store[q_col];
      prev_row_store[q_col]  <= q_pix;
      s1_pix                 <= q_pix;
      s1_col                 <= q_col;
      s1_row                 <= q_row;
      s1_flags               <= q_flags;
    end
  end

  // Squared channel differences: left/right and up/down
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq_next[k]     = chan_sq(left_pix[k*CH +: CH], rd_right[k*CH +: CH]);
      sq_next[k + 3] = chan_sq(rd_older[k*CH +: CH], s1_pix[k*CH +: CH]);
    end
  end

  // Shift the row above into the older store and the left window
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      older_row_store[s1_col] <= rd_above;
      left_pix                <= rd_above;
      s2_sq                   <= sq_next;
      s2_col                  <= s1_col;
      s2_row                  <= s1_row;
      s2_flags                <= s1_flags;
    end
  end

  // Sum the six squares
  always_comb begin
    sum_next = '0;
    for (int k = 0; k < 6; k++) begin
      sum_next = sum_next + egm_pkg::ENERGY_W'(s2_sq[k]);
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s3_energy     <= s2_flags.border ? egm_pkg::BORDER_ENERGY : sum_next;
      s3_has_second <= s2_flags.has_second;
      s3_last       <= s2_flags.last;
      s3_col        <= s2_col;
      s3_row        <= s2_row;
    end
  end

  // Stage valids; words of the first row carry no result and drop here
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s3_phase <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= q_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_free) begin
        s3_valid <= s2_valid & s2_flags.has_first;
        s3_phase <= 1'b0;
      end else if (out_take) begin
        s3_phase <= 1'b1;
      end
    end
  end

  // First result is the pixel above; second is this pixel's bottom border
  assign out_valid  = s3_valid;
  assign out_col    = egm_pkg::OUT_COL_W'(s3_col);
  assign out_row    = s3_phase ? s3_row : egm_pkg::ROW_W'(s3_row - 1'b1);
  assign energy     = s3_phase ? egm_pkg::BORDER_ENERGY : s3_energy;
  assign frame_done = s3_phase & s3_last;

endmodule : egm_back

`default_nettype wire

FILE: rtl/core/dual_gradient_energy_map.sv
// A pixel word passes through the queue, then the line store read, squares and result word stages.
// Throughput: one pixel word per cycle unless out_stall holds the flow; words of the last row give
// two results each, so there the output channel sets the pace.
// The line stores have one write and up to two reads per cycle, one pixel per access.
// Reset clears the position to (0, 0), the frame size to 640 x 480 and all valids;
// the line stores are not cleared and are filled by the first rows of each frame.
`timescale 1ns / 1ps
`default_nettype none

module dual_gradient_energy_map #(
  parameter int MAX_WIDTH = egm_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [egm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [egm_pkg::CFG_W-1:0]       cfg_data,
  // pixel input
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [egm_pkg::CHAN_W-1:0]      red,
  input  wire logic [egm_pkg::CHAN_W-1:0]      green,
  input  wire logic [egm_pkg::CHAN_W-1:0]      blue,
  // energy output
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [egm_pkg::OUT_COL_W-1:0]        out_col,
  output logic [egm_pkg::ROW_W-1:0]            out_row,
  output logic [egm_pkg::ENERGY_W-1:0]         energy,
  output logic                                 frame_done
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int FL_W  = $bits(egm_pkg::egm_flags_t);
  localparam int Q_W   = egm_pkg::PIX_W + COL_W + egm_pkg::ROW_W + FL_W;

  logic                      q_full;
  logic                      q_push;
  logic                      q_pop;
  logic                      q_valid;
  logic [egm_pkg::PIX_W-1:0] f_pix;
  logic [COL_W-1:0]          f_col;
  logic [egm_pkg::ROW_W-1:0] f_row;
  egm_pkg::egm_flags_t       f_flags;
  logic [egm_pkg::PIX_W-1:0] b_pix;
  logic [COL_W-1:0]          b_col;
  logic [egm_pkg::ROW_W-1:0] b_row;
  egm_pkg::egm_flags_t       b_flags;
  logic [Q_W-1:0]            q_head;

  egm_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_pix     (f_pix),
    .q_col     (f_col),
    .q_row     (f_row),
    .q_flags   (f_flags)
  );

  egm_queue #(
    .WIDTH (Q_W),
    .DEPTH (egm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({f_pix, f_col, f_row, f_flags}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  assign {b_pix, b_col, b_row, b_flags} = q_head;

  egm_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_pix      (b_pix),
    .q_col      (b_col),
    .q_row      (b_row),
    .q_flags    (b_flags),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_col    (out_col),
    .out_row    (out_row),
    .energy     (energy),
    .frame_done (frame_done)
  );

endmodule : dual_gradient_energy_map

`default_nettype wire

FILE: rtl/core/egm_checker.sv
// Port-level checks on the energy output of the dual-gradient energy map.
`timescale 1ns / 1ps
`default_nettype none

module egm_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            out_valid,
  input wire logic                            out_stall,
  input wire logic [egm_pkg::OUT_COL_W-1:0]   out_col,
  input wire logic [egm_pkg::ROW_W-1:0]       out_row,
  input wire logic [egm_pkg::ENERGY_W-1:0]    energy,
  input wire logic                            frame_done
);

  // Hold a stalled result word
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_col) && $stable(out_row) &&
                               $stable(energy) && $stable(frame_done))
    else $error("stalled result word changed");

  // Drop all results on reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // Close a frame only on a border-energy result outside the first row
  a_done_border: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> energy == egm_pkg::BORDER_ENERGY && out_row != '0)
    else $error("frame end on a non-border result");

  // Give the border energy in the first row and first column
  a_edge_energy: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_col == '0 || out_row == '0) |-> energy == egm_pkg::BORDER_ENERGY)
    else $error("edge pixel without border energy");

endmodule : egm_checker

bind dual_gradient_energy_map egm_checker u_egm_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_col    (out_col),
  .out_row    (out_row),
  .energy     (energy),
  .frame_done (frame_done)
);

`default_nettype wire

FILE: dv/tb_top.sv
// Testbench for the dual-gradient energy map: directed table, random frames, scoreboard.
`timescale 1ns / 1ps

module tb_top;

  // Spare register indexes that the block must ignore
  localparam logic [egm_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [egm_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  // Cycles to let the pipeline settle before a register write and at the end
  localparam int DRAIN_CYCLES = 8;
  localparam logic [egm_pkg::PIX_W-1:0] BLACK = 24'h000000;
  localparam logic [egm_pkg::PIX_W-1:0] WHITE = 24'hFFFFFF;

  typedef struct packed {
    logic [egm_pkg::OUT_COL_W-1:0] col;
    logic [egm_pkg::ROW_W-1:0]     row;
    logic [egm_pkg::ENERGY_W-1:0]  energy;
    logic                          done;
  } energy_word_t;

  // One row of the directed table: a register write or a pixel word
  typedef struct packed {
    logic                          is_cfg;
    logic [egm_pkg::CFG_IDX_W-1:0] idx;
    logic [egm_pkg::CFG_W-1:0]     data;
    logic [egm_pkg::PIX_W-1:0]     pix;
    logic                          typed;
    logic [1:0]                    n_typed;
    energy_word_t                  e0;
    energy_word_t                  e1;
  } stim_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [egm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [egm_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [egm_pkg::CHAN_W-1:0]    red = '0;
  logic [egm_pkg::CHAN_W-1:0]    green = '0;
  logic [egm_pkg::CHAN_W-1:0]    blue = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [egm_pkg::OUT_COL_W-1:0] out_col;
  logic [egm_pkg::ROW_W-1:0]     out_row;
  logic [egm_pkg::ENERGY_W-1:0]  energy;
  logic                          frame_done;

  // Predictor state: frame size, position, window and line stores
  bit   [egm_pkg::PIX_W-1:0]     line_above [egm_pkg::MAX_WIDTH_DEF];
  bit   [egm_pkg::PIX_W-1:0]     line_two_above [egm_pkg::MAX_WIDTH_DEF];
  bit   [egm_pkg::PIX_W-1:0]     win_left;
  bit   [egm_pkg::PIX_W-1:0]     win_above;
  logic [egm_pkg::ROW_W-1:0]     pos_col = '0;
  logic [egm_pkg::ROW_W-1:0]     pos_row = '0;
  logic [egm_pkg::CFG_W-1:0]     width_reg = egm_pkg::WIDTH_RESET;
  logic [egm_pkg::CFG_W-1:0]     height_reg = egm_pkg::HEIGHT_RESET;

  energy_word_t         pending_energy [$];
  int                   mismatch_count = 0;
  int                   stall_left = 0;
  bit                   steady = 1'b0;

  dual_gradient_energy_map i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_col    (out_col),
    .out_row    (out_row),
    .energy     (energy),
    .frame_done (frame_done)
  );

  always #5 clk = ~clk;

  // Bound the run
  initial begin
    #30_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int unsigned clamp_dim(input logic [egm_pkg::CFG_W-1:0] v,
                                            input int unsigned top);
    if (v < egm_pkg::MIN_DIM) return egm_pkg::MIN_DIM;
    if (v > top) return top;
    return 32'(v);
  endfunction

  function automatic int unsigned pix_dist(input logic [egm_pkg::PIX_W-1:0] a,
                                           input logic [egm_pkg::PIX_W-1:0] b);
    int unsigned sum;
    int d;
    int k;
    sum = 0;
    for (k = 0; k < 3; k++) begin
      d = int'(a[egm_pkg::CHAN_W*k +: egm_pkg::CHAN_W]) -
          int'(b[egm_pkg::CHAN_W*k +: egm_pkg::CHAN_W]);
      sum += d * d;
    end
    return sum;
  endfunction

  function automatic energy_word_t make_word(input int unsigned col, input int unsigned row,
                                             input int unsigned e, input bit done);
    energy_word_t w;
    w.col = col[egm_pkg::OUT_COL_W-1:0];
    w.row = row[egm_pkg::ROW_W-1:0];
    w.energy = e[egm_pkg::ENERGY_W-1:0];
    w.done = done;
    return w;
  endfunction

  function automatic stim_row_t cfg_row(input logic [egm_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [egm_pkg::CFG_W-1:0] val);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = val;
    return r;
  endfunction

  function automatic stim_row_t pix_row(input logic [egm_pkg::PIX_W-1:0] p);
    stim_row_t r;
    r = '0;
    r.pix = p;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic [egm_pkg::PIX_W-1:0] p, input int n,
                                          input energy_word_t e0, input energy_word_t e1);
    stim_row_t r;
    r = pix_row(p);
    r.typed = 1'b1;
    r.n_typed = n[1:0];
    r.e0 = e0;
    r.e1 = e1;
    return r;
  endfunction

  function automatic int draw_wait();
    return steady ? 0 : $urandom_range(0, 4);
  endfunction

  // Random pixel content: full random, saturated, smooth, or each channel either random or zero
  function automatic logic [egm_pkg::PIX_W-1:0] pick_pixel(input int style);
    logic [egm_pkg::PIX_W-1:0] p;
    int k;
    p = '0;
    for (k = 0; k < 3; k++) begin
      case (style)
        0: p[egm_pkg::CHAN_W*k +: egm_pkg::CHAN_W] = egm_pkg::CHAN_W'($urandom_range(0, 255));
        1: p[egm_pkg::CHAN_W*k +: egm_pkg::CHAN_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        2: p[egm_pkg::CHAN_W*k +: egm_pkg::CHAN_W] =
             egm_pkg::CHAN_W'(124 + $urandom_range(0, 7));
        default: p[egm_pkg::CHAN_W*k +: egm_pkg::CHAN_W] =
                   ($urandom_range(0, 2) == k) ? egm_pkg::CHAN_W'($urandom_range(0, 255)) :
                                                 '0;
      endcase
    end
    return p;
  endfunction

  // Energy words caused by one pixel word; advance the predictor state
  task automatic predict_energy(input logic [egm_pkg::PIX_W-1:0] pix, output int n,
                                output energy_word_t w0, output energy_word_t w1);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    int unsigned e;
    bit [egm_pkg::PIX_W-1:0] above;
    bit [egm_pkg::PIX_W-1:0] right;
    energy_word_t bottom;
    w = clamp_dim(width_reg, egm_pkg::MAX_WIDTH_DEF);
    h = clamp_dim(height_reg, egm_pkg::MAX_HEIGHT);
    c = 32'(pos_col);
    r = 32'(pos_row);
    if (c >= w) c = w - 1;
    if (r >= h) r = h - 1;
    n = 0;
    w0 = '0;
    w1 = '0;
    above = line_above[c];
    right = (c + 1 < w) ? line_above[c + 1] : '0;
    win_left = (c == 0) ? '0 : win_above;
    win_above = above;
    // Energy of the pixel above, once a row above exists
    if (r >= 1) begin
      if (c == 0 || c == w - 1 || r == 1) begin
        e = egm_pkg::BORDER_ENERGY;
      end else begin
        e = pix_dist(win_left, right) + pix_dist(line_two_above[c], pix);
      end
      w0 = make_word(c, r - 1, e, 1'b0);
      n = 1;
    end
    // Bottom row also gives its own border energy
    if (r == h - 1) begin
      bottom = make_word(c, r, egm_pkg::BORDER_ENERGY, c == w - 1);
      if (n == 0) w0 = bottom;
      else w1 = bottom;
      n++;
    end
    line_two_above[c] = above;
    line_above[c] = pix;
    if (c + 1 >= w) begin
      pos_col = '0;
      pos_row = (r + 1 >= h) ? '0 : egm_pkg::ROW_W'(r + 1);
    end else begin
      pos_col = egm_pkg::ROW_W'(c + 1);
      pos_row = egm_pkg::ROW_W'(r);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH %s", msg);
    mismatch_count++;
  endtask

  // Drive one pixel word and hold it until accepted
  task automatic send_pixel(input stim_row_t item);
    int gap;
    int n;
    energy_word_t w0;
    energy_word_t w1;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    predict_energy(item.pix, n, w0, w1);
    if (item.typed) begin
      n = int'(item.n_typed);
      w0 = item.e0;
      w1 = item.e1;
    end
    if (n > 0) pending_energy.push_back(w0);
    if (n > 1) pending_energy.push_back(w1);
    in_valid <= 1'b1;
    red <= item.pix[7:0];
    green <= item.pix[15:8];
    blue <= item.pix[23:16];
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  // Write a register once the block has drained
  task automatic write_register(input logic [egm_pkg::CFG_IDX_W-1:0] idx,
                                input logic [egm_pkg::CFG_W-1:0] val);
    in_valid <= 1'b0;
    while (pending_energy.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    // Any listed register restarts the frame
    if (idx == egm_pkg::REG_FRAME_WIDTH) begin
      width_reg = val;
      pos_col = '0;
      pos_row = '0;
    end else if (idx == egm_pkg::REG_FRAME_HEIGHT) begin
      height_reg = val;
      pos_col = '0;
      pos_row = '0;
    end
  endtask

  task automatic feed_pixels(input int count, input int style);
    int i;
    for (i = 0; i < count; i++) send_pixel(pix_row(pick_pixel(style)));
  endtask

  // Check each accepted energy word and draw the next stall
  always @(posedge clk) begin
    energy_word_t got;
    energy_word_t want;
    if (rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (out_valid === 1'b1 && out_stall === 1'b0) begin
      got = '{out_col, out_row, energy, frame_done};
      if (pending_energy.size() == 0) begin
        report_mismatch($sformatf("unexpected word col %0d row %0d energy %0d",
                                  got.col, got.row, got.energy));
      end else begin
        want = pending_energy.pop_front();
        if (got.col !== want.col)
          report_mismatch($sformatf("out_col %0d, want %0d", got.col, want.col));
        if (got.row !== want.row)
          report_mismatch($sformatf("out_row %0d, want %0d", got.row, want.row));
        if (got.energy !== want.energy)
          report_mismatch($sformatf("energy %0d, want %0d at (%0d,%0d)",
                                    got.energy, want.energy, want.col, want.row));
        if (got.done !== want.done)
          report_mismatch($sformatf("frame_done %0b, want %0b at (%0d,%0d)",
                                    got.done, want.done, want.col, want.row));
      end
      stall_left = draw_wait();
      out_stall <= (stall_left != 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  initial begin
    stim_row_t    directed_rows [$];
    stim_row_t    item;
    energy_word_t none;
    int           rand_items;
    int           area;
    int           count;
    int           wv;
    int           hv;

    none = '0;
    // Default 640 x 480 frame: first row gives nothing; spare indexes change nothing
    directed_rows.push_back(typed_row(BLACK, 0, none, none));
    directed_rows.push_back(typed_row(WHITE, 0, none, none));
    directed_rows.push_back(cfg_row(REG_SPARE_2, 12'hABC));
    directed_rows.push_back(typed_row(24'h00FF00, 0, none, none));
    directed_rows.push_back(cfg_row(REG_SPARE_3, 12'hFFF));
    // Size below range clamps to 3 x 3
    directed_rows.push_back(cfg_row(egm_pkg::REG_FRAME_WIDTH, 12'd0));
    directed_rows.push_back(cfg_row(egm_pkg::REG_FRAME_HEIGHT, 12'd1));
    directed_rows.push_back(typed_row(BLACK, 0, none, none));
    directed_rows.push_back(typed_row(BLACK, 0, none, none));
    directed_rows.push_back(typed_row(BLACK, 0, none, none));
    directed_rows.push_back(typed_row(BLACK, 1,
                                      make_word(0, 0, egm_pkg::BORDER_ENERGY, 0), none));
    directed_rows.push_back(typed_row(24'h123456, 1,
                                      make_word(1, 0, egm_pkg::BORDER_ENERGY, 0), none));
    directed_rows.push_back(typed_row(WHITE, 1,
                                      make_word(2, 0, egm_pkg::BORDER_ENERGY, 0), none));
    directed_rows.push_back(typed_row(24'h808080, 2,
                                      make_word(0, 1, egm_pkg::BORDER_ENERGY, 0),
                                      make_word(0, 2, egm_pkg::BORDER_ENERGY, 0)));
    // Center pixel sees black against white both ways: largest energy
    directed_rows.push_back(typed_row(WHITE, 2, make_word(1, 1, 390150, 0),
                                      make_word(1, 2, egm_pkg::BORDER_ENERGY, 0)));
    directed_rows.push_back(typed_row(BLACK, 2,
                                      make_word(2, 1, egm_pkg::BORDER_ENERGY, 0),
                                      make_word(2, 2, egm_pkg::BORDER_ENERGY, 1)));
    // Restart in the middle of a row, then a 4 x 3 frame with single-channel steps
    directed_rows.push_back(cfg_row(egm_pkg::REG_FRAME_WIDTH, 12'd4));
    directed_rows.push_back(pix_row(24'h0000FF));
    directed_rows.push_back(pix_row(24'h00FF00));
    directed_rows.push_back(cfg_row(egm_pkg::REG_FRAME_HEIGHT, 12'd3));
    directed_rows.push_back(pix_row(24'h000000));
    directed_rows.push_back(pix_row(24'h0000FF));
    directed_rows.push_back(pix_row(24'h00FF00));
    directed_rows.push_back(pix_row(24'hFF0000));
    directed_rows.push_back(pix_row(24'h0A141E));
    directed_rows.push_back(pix_row(24'hFFFFFF));
    directed_rows.push_back(pix_row(24'h000000));
    directed_rows.push_back(pix_row(24'h7F7F7F));
    directed_rows.push_back(pix_row(24'hFF00FF));
    directed_rows.push_back(pix_row(24'h00FFFF));
    directed_rows.push_back(pix_row(24'hFFFF00));
    directed_rows.push_back(pix_row(24'h010203));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      item = directed_rows[i];
      if (item.is_cfg) write_register(item.idx, item.data);
      else send_pixel(item);
    end

    // Random small frames, mostly whole, some cut short or run on without a restart
    rand_items = 0;
    while (rand_items < 64) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 3) == 0)
          write_register($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                         egm_pkg::CFG_W'($urandom_range(0, 4095)));
        wv = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 9);
        hv = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
        if ($urandom_range(0, 1)) begin
          write_register(egm_pkg::REG_FRAME_WIDTH, egm_pkg::CFG_W'(wv));
          write_register(egm_pkg::REG_FRAME_HEIGHT, egm_pkg::CFG_W'(hv));
        end else begin
          write_register(egm_pkg::REG_FRAME_HEIGHT, egm_pkg::CFG_W'(hv));
          write_register(egm_pkg::REG_FRAME_WIDTH, egm_pkg::CFG_W'(wv));
        end
      end
      area = clamp_dim(width_reg, egm_pkg::MAX_WIDTH_DEF) *
             clamp_dim(height_reg, egm_pkg::MAX_HEIGHT);
      count = ($urandom_range(0, 4) == 0) ? $urandom_range(1, area - 1) : area;
      if (count > 72 - rand_items) count = 72 - rand_items;
      feed_pixels(count, $urandom_range(0, 3));
      rand_items += count;
    end

    // Widest frame, width clamped from above: part of the first row
    steady = 1'b0;
    write_register(egm_pkg::REG_FRAME_WIDTH, 12'hFFF);
    write_register(egm_pkg::REG_FRAME_HEIGHT, 12'd0);
    feed_pixels(10, $urandom_range(0, 3));
    // Tallest frame, height clamped from above: first rows only
    write_register(egm_pkg::REG_FRAME_WIDTH, 12'd3);
    write_register(egm_pkg::REG_FRAME_HEIGHT, 12'hFFF);
    feed_pixels(egm_pkg::MIN_DIM * 5, $urandom_range(0, 3));

    // Drain and decide
    in_valid <= 1'b0;
    while (pending_energy.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/egm_pkg.sv
rtl/core/egm_front.sv
rtl/core/egm_queue.sv
rtl/core/egm_back.sv
rtl/core/dual_gradient_energy_map.sv
rtl/core/egm_checker.sv
dv/tb_top.sv
